### rtl/semsvf_pkg.sv
package semsvf_pkg;

  // default sample width
  localparam int SAMPLE_BITS_DEF = 24;

  // register widths and configuration port
  localparam int ALPHA_W    = 25;
  localparam int GAIN_W     = 24;
  localparam int DSUM_W     = 24;
  localparam int MIX_W      = 17;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ZERO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATOR_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_SUM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MODE   = 3'd4;

  // response modes, anything above band-stop is bypass
  localparam logic [MODE_W-1:0] MODE_LOWPASS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BANDPASS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BANDSTOP = 3'd3;

  // register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 25'd16777216;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd1048576;
  localparam logic [DSUM_W-1:0]  DSUM_RST  = 24'd1048576;
  localparam logic [MIX_W-1:0]   MIX_RST   = 17'd32768;
  localparam logic [MIX_W-1:0]   MIX_ONE   = 17'd65536;

  // datapath widths
  localparam int ST_W   = 32;  // integrator states and filter taps
  localparam int D_W    = 38;  // loop difference
  localparam int DLO_W  = 19;  // low split of the difference
  localparam int GP_W   = 37;  // rounded g*v products
  localparam int COEF_W = 25;
  localparam int OPND_W = 33;
  localparam int PROD_W = 59;
  localparam int ACC_W  = 64;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [GAIN_W-1:0]  gain;
    logic [DSUM_W-1:0]  dsum;
    logic [MIX_W-1:0]   mix;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

  // microcode fields
  typedef enum logic [2:0] {
    COEF_NONE, COEF_DSUM, COEF_ALPHA, COEF_GAIN, COEF_MIX, COEF_NMIX
  } coef_sel_t;

  typedef enum logic [2:0] {
    OPND_S1, OPND_DLO, OPND_DHI, OPND_HPF, OPND_BPF, OPND_LPF
  } opnd_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP, ALU_DIFF, ALU_ALO, ALU_HPF, ALU_BPF, ALU_S1, ALU_LPF, ALU_S2,
    ALU_BACC, ALU_OUT_BLEND, ALU_OUT_SEL
  } alu_op_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_BYPASS, JMP_SIMPLE
  } jump_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_MUL_D   = 4'd0;
  localparam step_t STEP_DIFF    = 4'd1;
  localparam step_t STEP_MUL_ALO = 4'd2;
  localparam step_t STEP_MUL_AHI = 4'd3;
  localparam step_t STEP_HPF     = 4'd4;
  localparam step_t STEP_MUL_GH  = 4'd5;
  localparam step_t STEP_BPF     = 4'd6;
  localparam step_t STEP_MUL_GB  = 4'd7;
  localparam step_t STEP_LPF     = 4'd8;
  localparam step_t STEP_S2      = 4'd9;
  localparam step_t STEP_BACC    = 4'd10;
  localparam step_t STEP_BLEND   = 4'd11;
  localparam step_t STEP_FIN     = 4'd12;

  typedef struct packed {
    coef_sel_t coef;
    opnd_sel_t opnd;
    alu_op_t   alu;
    jump_t     jmp;
    step_t     target;
    logic      last;
  } ctrl_t;

  // jump conditions from the response mode
  typedef struct packed {
    logic bypass;
    logic simple;
  } seq_flag_t;

  // sequencer status toward the handshake logic
  typedef struct packed {
    logic busy;
    logic emit;
  } seq_stat_t;

  localparam ctrl_t CTRL_NOP = '{COEF_NONE, OPND_S1, ALU_NOP, JMP_NONE, STEP_MUL_D, 1'b0};

  // control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    case (s)
      STEP_MUL_D: begin
        c.coef = COEF_DSUM; c.opnd = OPND_S1;
        c.jmp = JMP_BYPASS; c.target = STEP_FIN;
      end
      STEP_DIFF:    c.alu = ALU_DIFF;
      STEP_MUL_ALO: begin
        c.coef = COEF_ALPHA; c.opnd = OPND_DLO;
      end
      STEP_MUL_AHI: begin
        c.coef = COEF_ALPHA; c.opnd = OPND_DHI; c.alu = ALU_ALO;
      end
      STEP_HPF:     c.alu = ALU_HPF;
      STEP_MUL_GH: begin
        c.coef = COEF_GAIN; c.opnd = OPND_HPF;
      end
      STEP_BPF:     c.alu = ALU_BPF;
      STEP_MUL_GB: begin
        c.coef = COEF_GAIN; c.opnd = OPND_BPF; c.alu = ALU_S1;
      end
      STEP_LPF:     c.alu = ALU_LPF;
      STEP_S2: begin
        c.coef = COEF_MIX; c.opnd = OPND_HPF; c.alu = ALU_S2;
        c.jmp = JMP_SIMPLE; c.target = STEP_FIN;
      end
      STEP_BACC: begin
        c.coef = COEF_NMIX; c.opnd = OPND_LPF; c.alu = ALU_BACC;
      end
      STEP_BLEND: begin
        c.alu = ALU_OUT_BLEND; c.last = 1'b1;
      end
      STEP_FIN: begin
        c.alu = ALU_OUT_SEL; c.last = 1'b1;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

### rtl/semsvf_seq.sv
module semsvf_seq import semsvf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      out_hold,
  input  seq_flag_t flags,
  output ctrl_t     ctrl,
  output seq_stat_t stat
);

  typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

  seq_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  ctrl_t      word;
  logic       take_jump;

  // control word of the current step
  assign word = ucode(step_r);
  assign ctrl = (state_r == SQ_RUN) ? word : CTRL_NOP;

  assign take_jump = ((word.jmp == JMP_BYPASS) && flags.bypass) ||
                     ((word.jmp == JMP_SIMPLE) && flags.simple);

  assign stat.busy = (state_r == SQ_RUN);
  assign stat.emit = (state_r == SQ_RUN) && word.last && !out_hold;

  // step counter and jumps
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          step_nxt  = STEP_MUL_D;
        end
      end
      SQ_RUN: begin
        if (word.last) begin
          if (!out_hold) begin
            state_nxt = SQ_IDLE;
            step_nxt  = STEP_MUL_D;
          end
        end else if (take_jump) begin
          step_nxt = word.target;
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      step_r  <= STEP_MUL_D;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### rtl/semsvf_dp.sv
module semsvf_dp import semsvf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  ctrl_t                         ctrl,
  input  cfg_t                          cfg,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam logic signed [ACC_W-1:0] ONE_W   = 1;
  localparam logic signed [ACC_W-1:0] ST_MAX  = (ONE_W <<< (ST_W - 1)) - ONE_W;
  localparam logic signed [ACC_W-1:0] ST_MIN  = -ST_MAX - ONE_W;
  localparam logic signed [ACC_W-1:0] SMP_MAX = (ONE_W <<< (SAMPLE_BITS - 1)) - ONE_W;
  localparam logic signed [ACC_W-1:0] SMP_MIN = -SMP_MAX - ONE_W;

  // round to nearest, ties up, by a constant shift
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                   input int unsigned s);
    return (v + (ONE_W <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    return c[ST_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
    return c[SAMPLE_BITS-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [ST_W-1:0]   s1_r, s1_nxt, s2_r, s2_nxt;
  logic signed [ST_W-1:0]   hpf_r, hpf_nxt, bpf_r, bpf_nxt, lpf_r, lpf_nxt;
  logic signed [GP_W-1:0]   ghp_r, ghp_nxt, gbp_r, gbp_nxt;
  logic signed [D_W-1:0]    d_r, d_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [COEF_W-1:0]        coef;
  logic signed [OPND_W-1:0] opnd;
  logic [MIX_W-1:0]         mix_eff, mix_inv;
  logic signed [ACC_W-1:0]  prod_w, prod_rnd20, ghp_w, gbp_w, tmp_w;

  // blend weight clamped to one
  assign mix_eff = (cfg.mix > MIX_ONE) ? MIX_ONE : cfg.mix;
  assign mix_inv = MIX_ONE - mix_eff;

  // coefficient select
  always_comb begin
    case (ctrl.coef)
      COEF_DSUM:  coef = COEF_W'(cfg.dsum);
      COEF_ALPHA: coef = COEF_W'(cfg.alpha);
      COEF_GAIN:  coef = COEF_W'(cfg.gain);
      COEF_MIX:   coef = COEF_W'(mix_eff);
      COEF_NMIX:  coef = COEF_W'(mix_inv);
      default:    coef = '0;
    endcase
  end

  // operand select
  always_comb begin
    case (ctrl.opnd)
      OPND_S1:  opnd = OPND_W'(s1_r);
      OPND_DLO: opnd = $signed({{(OPND_W-DLO_W){1'b0}}, d_r[DLO_W-1:0]});
      OPND_DHI: opnd = OPND_W'($signed(d_r[D_W-1:DLO_W]));
      OPND_HPF: opnd = OPND_W'(hpf_r);
      OPND_BPF: opnd = OPND_W'(bpf_r);
      OPND_LPF: opnd = OPND_W'(lpf_r);
      default:  opnd = '0;
    endcase
  end

  // shared multiplier
  assign prod_nxt = $signed({1'b0, coef}) * opnd;

  assign prod_w     = ACC_W'(prod_r);
  assign prod_rnd20 = rshr(prod_w, 20);
  assign ghp_w      = ACC_W'(ghp_r);
  assign gbp_w      = ACC_W'(gbp_r);

  // accumulate, round and saturate
  always_comb begin
    s1_nxt  = s1_r;
    s2_nxt  = s2_r;
    hpf_nxt = hpf_r;
    bpf_nxt = bpf_r;
    lpf_nxt = lpf_r;
    ghp_nxt = ghp_r;
    gbp_nxt = gbp_r;
    d_nxt   = d_r;
    acc_nxt = acc_r;
    result  = '0;
    tmp_w   = '0;
    case (ctrl.alu)
      ALU_DIFF: begin
        tmp_w = ACC_W'(x_r) - ACC_W'(s2_r) - prod_rnd20;
        d_nxt = tmp_w[D_W-1:0];
      end
      ALU_ALO:  acc_nxt = prod_w + (ONE_W <<< 23);
      ALU_HPF: begin
        tmp_w   = acc_r + (prod_w <<< DLO_W);
        hpf_nxt = sat_st(tmp_w >>> 24);
      end
      ALU_BPF: begin
        ghp_nxt = prod_rnd20[GP_W-1:0];
        bpf_nxt = sat_st(prod_rnd20 + ACC_W'(s1_r));
      end
      ALU_S1:   s1_nxt = sat_st(ghp_w + ACC_W'(bpf_r));
      ALU_LPF: begin
        gbp_nxt = prod_rnd20[GP_W-1:0];
        lpf_nxt = sat_st(prod_rnd20 + ACC_W'(s2_r));
      end
      ALU_S2:   s2_nxt = sat_st(gbp_w + ACC_W'(lpf_r));
      ALU_BACC: acc_nxt = prod_w + (ONE_W <<< 15);
      ALU_OUT_BLEND: begin
        tmp_w  = acc_r + prod_w;
        result = sat_smp(tmp_w >>> 16);
      end
      ALU_OUT_SEL: begin
        case (cfg.mode)
          MODE_LOWPASS:  result = sat_smp(ACC_W'(lpf_r));
          MODE_HIGHPASS: result = sat_smp(ACC_W'(hpf_r));
          MODE_BANDPASS: result = sat_smp(ACC_W'(bpf_r));
          default:       result = x_r;
        endcase
      end
      default: ;
    endcase
  end

  // integrator states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= sample;
    end
    if (ctrl.coef != COEF_NONE) begin
      prod_r <= prod_nxt;
    end
    hpf_r <= hpf_nxt;
    bpf_r <= bpf_nxt;
    lpf_r <= lpf_nxt;
    ghp_r <= ghp_nxt;
    gbp_r <= gbp_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
  end

endmodule

### rtl/sem_state_variable_filter_top.sv
// Second-order state-variable filter with a microcoded sequencer.
// Input channel: in_valid / in_stall with one signed sample in in_sample_in.
// Result channel: out_valid / out_stall with one signed sample in out_sample_out.
// An item moves at a clock edge where valid is high and stall is low.
// The user writes coefficients via cfg_wr_en / cfg_index / cfg_data only while idle; the block does not enforce it.
// Each item runs a program on one shared 26x33 multiplier, one step per cycle
// except while the final step is held (see below):
//   low-pass, high-pass, band-pass: 11 steps
//   band-stop blend: 12 steps (two more products)
//   bypass: 2 steps
// in_stall is high while the program runs, so no new item is taken before it ends.
// The result waits in an output register; a new item can be taken while it
// waits. If the register is still full at the final step, the sequencer holds
// there until the receiver takes the waiting result.
// Reset clears both integrator states, loads the default coefficients and
// empties the output register.
module sem_state_variable_filter_top import semsvf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  ctrl_t     ctrl;
  seq_stat_t stat;
  seq_flag_t flags;
  logic      accept, out_hold;
  logic      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] result;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  assign in_stall       = stat.busy;
  assign accept         = in_valid && !stat.busy;
  assign out_hold       = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  assign flags.bypass = (cfg_r.mode > MODE_BANDSTOP);
  assign flags.simple = (cfg_r.mode < MODE_BANDSTOP);

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALPHA_ZERO:      cfg_nxt.alpha = cfg_data[ALPHA_W-1:0];
        REG_INTEGRATOR_GAIN: cfg_nxt.gain  = cfg_data[GAIN_W-1:0];
        REG_DAMPING_SUM:     cfg_nxt.dsum  = cfg_data[DSUM_W-1:0];
        REG_BLEND_MIX:       cfg_nxt.mix   = cfg_data[MIX_W-1:0];
        REG_RESPONSE_MODE:   cfg_nxt.mode  = cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ALPHA_RST, GAIN_RST, DSUM_RST, MIX_RST, MODE_LOWPASS};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // output register
  assign out_valid_nxt = stat.emit || out_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      out_data_r <= result;
    end
  end

  semsvf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_hold (out_hold),
    .flags    (flags),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  semsvf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .sample (in_sample_in),
    .ctrl   (ctrl),
    .cfg    (cfg_r),
    .result (result)
  );

endmodule

### rtl/semsvf_check.sv
module semsvf_check import semsvf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted item keeps the input stalled
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input not stalled while an item is in work");

  // a new result only appears at the end of a program run
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

endmodule

bind sem_state_variable_filter_top semsvf_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_semsvf_check (.*);

### sim/testbench.sv
module testbench;
  import semsvf_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 100;

  // modes the package leaves unnamed: everything above band-stop is bypass
  localparam logic [MODE_W-1:0] MODE_BYPASS = MODE_BANDSTOP + 1'b1;
  localparam logic [MODE_W-1:0] MODE_LAST   = '1;

  // register extremes
  localparam int unsigned ALPHA_MAX = (1 << ALPHA_W) - 1;
  localparam int unsigned GAIN_MAX  = (1 << GAIN_W) - 1;
  localparam int unsigned DSUM_MAX  = (1 << DSUM_W) - 1;
  localparam int unsigned MIX_MAX   = (1 << MIX_W) - 1;

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  // filter predictor and queue of expected output samples
  class svf_scoreboard;
    logic [ALPHA_W-1:0] alpha;
    logic [GAIN_W-1:0]  gain;
    logic [DSUM_W-1:0]  dsum;
    logic [MIX_W-1:0]   mix;
    logic [MODE_W-1:0]  mode;
    longint             integ1;
    longint             integ2;
    sample_t            expected_samples[$];
    int                 errors;
    int                 results_seen;

    function new();
      alpha        = ALPHA_RST;
      gain         = GAIN_RST;
      dsum         = DSUM_RST;
      mix          = MIX_RST;
      mode         = MODE_LOWPASS;
      integ1       = 0;
      integ2       = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ALPHA_ZERO:      alpha = value[ALPHA_W-1:0];
        REG_INTEGRATOR_GAIN: gain  = value[GAIN_W-1:0];
        REG_DAMPING_SUM:     dsum  = value[DSUM_W-1:0];
        REG_BLEND_MIX:       mix   = value[MIX_W-1:0];
        REG_RESPONSE_MODE:   mode  = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // right shift rounding to nearest, ties upward
    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one filter step, updates both integrators unless in bypass
    function sample_t filter_step(sample_t x);
      longint xv, d, hp, bp, lp, ghp, gbp, y, m, g;
      xv = x;
      g  = longint'(gain);
      m  = (mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix);
      if (mode > MODE_BANDSTOP) return x;
      d   = xv - round_shift(longint'(dsum) * integ1, 20) - integ2;
      hp  = clamp(round_shift(longint'(alpha) * d, 24), 32);
      ghp = round_shift(g * hp, 20);
      bp  = clamp(ghp + integ1, 32);
      gbp = round_shift(g * bp, 20);
      lp  = clamp(gbp + integ2, 32);
      integ1 = clamp(ghp + bp, 32);
      integ2 = clamp(gbp + lp, 32);
      case (mode)
        MODE_LOWPASS:  y = lp;
        MODE_HIGHPASS: y = hp;
        MODE_BANDPASS: y = bp;
        default:       y = round_shift(m * hp + (longint'(MIX_ONE) - m) * lp, 16);
      endcase
      y = clamp(y, SB);
      return y[SB-1:0];
    endfunction

    function void note_sample(sample_t x);
      expected_samples.push_back(filter_step(x));
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      results_seen++;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("output %0d: got %0d with nothing pending", results_seen, got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("output %0d: expected %0d, got %0d", results_seen, want, got);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  sample_t                  in_sample_in;
  logic                     out_valid;
  logic                     out_stall;
  sample_t                  out_sample_out;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  svf_scoreboard sb;
  bit            calm;
  int            settings_used;

  sem_state_variable_filter_top #(.SAMPLE_BITS(SB)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // result side: random stall runs, check every taken item
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_sample(out_sample_out);
      if (calm) stall_left = 0;
      else if (stall_left == 0) stall_left = pick_idle();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic send_sample(input sample_t x);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (in_stall);
    sb.note_sample(x);
  endtask

  // drain all pending outputs, then let the sequencer settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_coefficients(input int unsigned alpha, input int unsigned gain,
                                   input int unsigned dsum, input int unsigned mix,
                                   input logic [MODE_W-1:0] mode, input bit stray);
    wait_idle();
    write_reg(REG_ALPHA_ZERO, CFG_DATA_W'(alpha));
    write_reg(REG_INTEGRATOR_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_DAMPING_SUM, CFG_DATA_W'(dsum));
    write_reg(REG_BLEND_MIX, CFG_DATA_W'(mix));
    write_reg(REG_RESPONSE_MODE, CFG_DATA_W'(mode));
    // unmapped index, must change nothing
    if (stray) write_reg(CFG_IDX_W'(REG_RESPONSE_MODE + $urandom_range(1, 3)),
                         CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // coefficients from a prewarped gain and a damping value
  function automatic void tuned_coefficients(output int unsigned alpha,
                                             output int unsigned gain,
                                             output int unsigned dsum);
    real gr;
    real rr;
    gain  = $urandom_range(1 << 12, 3 << 20);
    gr    = real'(gain) / 1048576.0;
    rr    = $urandom_range(30, 3000) / 1000.0;
    dsum  = $rtoi((2.0 * rr + gr) * 1048576.0 + 0.5);
    alpha = $rtoi(16777216.0 / (1.0 + 2.0 * rr * gr + gr * gr) + 0.5);
  endfunction

  // sample mix: full range, small values, held levels, rails
  function automatic sample_t next_sample(sample_t prev);
    int unsigned r;
    logic [31:0] bits;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      bits = $urandom;
      return bits[SB-1:0];
    end
    if (r < 80) begin
      v = int'($urandom_range(0, 512)) - 256;
      return v[SB-1:0];
    end
    if (r < 90) return prev;
    return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  task automatic run_phase(input int p);
    int unsigned alpha, gain, dsum, mix;
    logic [MODE_W-1:0] mode;
    sample_t s;
    calm = (p % 4 == 2);
    tuned_coefficients(alpha, gain, dsum);
    mix  = $urandom_range(0, MIX_ONE);
    mode = MODE_W'($urandom_range(MODE_LOWPASS, MODE_BANDSTOP));
    case (p % 7)
      3: begin
        mode = MODE_BANDSTOP;
        mix  = $urandom_range(0, MIX_MAX);
      end
      4: begin
        alpha = $urandom_range(0, ALPHA_MAX);
        gain  = $urandom_range(0, GAIN_MAX);
        dsum  = $urandom_range(0, DSUM_MAX);
        mix   = $urandom_range(0, MIX_MAX);
        mode  = MODE_W'($urandom_range(MODE_LOWPASS, MODE_LAST));
      end
      5: mode = MODE_W'($urandom_range(MODE_BYPASS, MODE_LAST));
      6: begin
        case ($urandom_range(0, 2))
          0:       alpha = 0;
          1:       alpha = ALPHA_MAX;
          default: alpha = ALPHA_RST;
        endcase
        gain = ($urandom_range(0, 1) != 0) ? GAIN_MAX : 0;
        dsum = ($urandom_range(0, 1) != 0) ? DSUM_MAX : 0;
      end
      default: ;
    endcase
    load_coefficients(alpha, gain, dsum, mix, mode, $urandom_range(0, 2) == 0);
    s = '0;
    repeat (PHASE_ITEMS) begin
      s = next_sample(s);
      send_sample(s);
    end
  endtask

  // stimulus
  initial begin
    sb            = new();
    calm          = 1'b0;
    settings_used = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample_in  = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients, low-pass
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);

    // high-pass and band-pass at the default tuning
    load_coefficients(ALPHA_RST, GAIN_RST, DSUM_RST, MIX_RST, MODE_HIGHPASS, 1'b1);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(SAMPLE_MAX);
    load_coefficients(ALPHA_RST, GAIN_RST, DSUM_RST, MIX_RST, MODE_BANDPASS, 1'b0);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(sample_t'(12345));

    // blend weight above one, then zero
    load_coefficients(ALPHA_RST, GAIN_RST, DSUM_RST, MIX_MAX, MODE_BANDSTOP, 1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-100));
    load_coefficients(ALPHA_RST, GAIN_RST, DSUM_RST, 0, MODE_BANDSTOP, 1'b0);
    send_sample(sample_t'(4000));
    send_sample(sample_t'(-4000));

    // bypass keeps the integrators
    load_coefficients(ALPHA_RST, GAIN_RST, DSUM_RST, MIX_RST, MODE_LAST, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(-1));

    // input gain near two with full loop gain drives every saturation
    load_coefficients(ALPHA_MAX, GAIN_MAX, 0, MIX_RST, MODE_HIGHPASS, 1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // all coefficients zero
    load_coefficients(0, 0, 0, 0, MODE_LOWPASS, 1'b0);
    send_sample(sample_t'(5));
    send_sample(sample_t'(-5));

    // random settings and samples
    for (int p = 0; p < PHASES; p++) run_phase(p);

    wait_idle();
    $display("summary: %0d samples checked over %0d coefficient settings, %0d errors",
             sb.results_seen, settings_used, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
